@@ src/uwnt_pkg.sv @@
// ----------------------------------------------------------------------------
// uwnt_pkg
// Shared types, constants and byte classification for the word and number
// tokenizer: queue entries, result beats and scanner mode codes.
// ----------------------------------------------------------------------------
package uwnt_pkg;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // output burst buffer: one multibyte letter gives at most four beats
   localparam int BURST_DEPTH = 4;
   localparam int BSEL_W      = 2;
   localparam int BCNT_W      = 3;

   typedef logic [QPTR_W-1:0] qptr_type;
   typedef logic [QCNT_W-1:0] qcnt_type;
   typedef logic [BCNT_W-1:0] bcnt_type;

   localparam qcnt_type QUEUE_FULL_CNT  = QCNT_W'(QUEUE_DEPTH);
   localparam bcnt_type BURST_DEPTH_CNT = BCNT_W'(BURST_DEPTH);

   // byte values
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0   = 8'h30;
   localparam logic [7:0] CH_DIGIT_9   = 8'h39;
   localparam logic [7:0] CH_APOS      = 8'h27;
   localparam logic [7:0] CH_HYPHEN    = 8'h2D;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] LEAD2_MIN    = 8'hC0;
   localparam logic [7:0] LEAD3_MIN    = 8'hE0;
   localparam logic [7:0] LEAD_END     = 8'hF0;
   localparam logic [7:0] LOWER_OFFSET = 8'd32;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_WORD = 2'd1,
      MODE_NUM  = 2'd2
   } mode_type;

   typedef struct packed {
      logic alpha;
      logic digit;
      logic dot;
      logic joiner;
      logic lead2;
      logic lead3;
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           end_of_line;
      byte_class_type cls;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type head;
   } queue_out_type;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       is_number;
      logic       token_last;
   } result_type;

   typedef struct packed {
      bcnt_type                           cnt;
      result_type [BURST_DEPTH-1:0]       items;
   } burst_push_type;

   // sort one text byte into the classes the scanner needs
   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      c.alpha  = ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
                 ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z));
      c.digit  = (b >= CH_DIGIT_0) && (b <= CH_DIGIT_9);
      c.dot    = (b == CH_DOT);
      c.joiner = (b == CH_APOS) || (b == CH_HYPHEN);
      c.lead2  = (b >= LEAD2_MIN) && (b < LEAD3_MIN);
      c.lead3  = (b >= LEAD3_MIN) && (b < LEAD_END);
      return c;
   endfunction

   // A-Z to a-z, everything else as is
   function automatic logic [7:0] lower_byte(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) begin
         r = b + LOWER_OFFSET;
      end
      return r;
   endfunction

endpackage

@@ src/uwnt_front.sv @@
// ----------------------------------------------------------------------------
// uwnt_front
// Input side: takes request beats while the queue has room and tags each
// byte with its character class before it is queued.
// ----------------------------------------------------------------------------
module uwnt_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_end_of_line,
   input  logic                      queue_full,
   output logic                      push,
   output uwnt_pkg::queue_entry_type entry
);

   // stall only on a full queue
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // classify the byte on the way in
   always_comb begin
      entry.data_byte   = req_data_byte;
      entry.end_of_line = req_end_of_line;
      entry.cls         = uwnt_pkg::classify(req_data_byte);
   end

endmodule

@@ src/uwnt_queue.sv @@
// ----------------------------------------------------------------------------
// uwnt_queue
// Short queue of classified bytes between the front and the scanner, so
// each side can stall on its own.
// ----------------------------------------------------------------------------
module uwnt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  uwnt_pkg::queue_entry_type entry,
   input  logic                      pop,
   output logic                      full,
   output uwnt_pkg::queue_out_type   q_out
);

   uwnt_pkg::queue_entry_type q_ff [uwnt_pkg::QUEUE_DEPTH];
   uwnt_pkg::qptr_type        wr_ptr_ff;
   uwnt_pkg::qptr_type        wr_ptr_in;
   uwnt_pkg::qptr_type        rd_ptr_ff;
   uwnt_pkg::qptr_type        rd_ptr_in;
   uwnt_pkg::qcnt_type        cnt_ff;
   uwnt_pkg::qcnt_type        cnt_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + uwnt_pkg::qptr_type'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + uwnt_pkg::qptr_type'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + uwnt_pkg::qcnt_type'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - uwnt_pkg::qcnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   assign full        = (cnt_ff == uwnt_pkg::QUEUE_FULL_CNT);
   assign q_out.valid = (cnt_ff != '0);
   assign q_out.head  = q_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cnt_ff != '0))
      else $error("queue popped while empty");
`endif

endmodule

@@ src/uwnt_scan.sv @@
// ----------------------------------------------------------------------------
// uwnt_scan
// Token scanner: runs one queued byte or one end-of-line step per cycle when
// its beats fit, holds the last token byte until it is known whether it ends
// the token, and rescans the held bytes of an unfinished letter at line end.
// ----------------------------------------------------------------------------
module uwnt_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  uwnt_pkg::queue_out_type  q_out,
   output logic                     pop,
   input  uwnt_pkg::bcnt_type       space,
   output uwnt_pkg::burst_push_type push
);

   uwnt_pkg::mode_type mode_ff;
   uwnt_pkg::mode_type mode_in;
   logic [7:0]         held_byte_ff;
   logic [7:0]         held_byte_in;
   logic               held_valid_ff;
   logic               held_valid_in;
   logic [7:0]         pend_ff [3];
   logic [7:0]         pend_in [3];
   logic [1:0]         pend_cnt_ff;
   logic [1:0]         pend_cnt_in;
   logic [1:0]         owed_ff;
   logic [1:0]         owed_in;
   logic [7:0]         rep_ff [2];
   logic [7:0]         rep_in [2];
   logic [1:0]         rep_cnt_ff;
   logic [1:0]         rep_cnt_in;

   logic                             do_feed;
   logic                             do_flush;
   logic                             pop_step;
   logic                             go;
   logic                             end_tok;
   logic                             top;
   logic [7:0]                       feed_byte;
   uwnt_pkg::byte_class_type         feed_cls;
   uwnt_pkg::bcnt_type               res_cnt;
   uwnt_pkg::result_type [uwnt_pkg::BURST_DEPTH-1:0] res_list;

   // one scanner step: next state and the result beats it gives
   always_comb begin
      mode_in       = mode_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      pend_in       = pend_ff;
      pend_cnt_in   = pend_cnt_ff;
      owed_in       = owed_ff;
      rep_in        = rep_ff;
      rep_cnt_in    = rep_cnt_ff;
      res_list      = '0;
      res_cnt       = '0;
      do_feed       = 1'b0;
      do_flush      = 1'b0;
      pop_step      = 1'b0;
      end_tok       = 1'b0;
      top           = 1'b0;
      feed_byte     = q_out.head.data_byte;
      feed_cls      = q_out.head.cls;

      // pick the step: rescan bytes first, then the queue head
      if (rep_cnt_ff != 2'd0) begin
         feed_byte  = rep_ff[0];
         feed_cls   = uwnt_pkg::classify(rep_ff[0]);
         do_feed    = 1'b1;
         rep_in[0]  = rep_ff[1];
         rep_cnt_in = rep_cnt_ff - 2'd1;
      end else if (q_out.valid) begin
         if (q_out.head.end_of_line) begin
            do_flush = 1'b1;
         end else begin
            do_feed  = 1'b1;
            pop_step = 1'b1;
         end
      end

      if (do_feed) begin
         if ((pend_cnt_in != 2'd0) && (owed_in != 2'd0)) begin
            // inside a multibyte letter
            if (owed_in == 2'd1) begin
               if (held_valid_in) begin
                  res_list[res_cnt[uwnt_pkg::BSEL_W-1:0]] = '{token_byte: held_byte_in,
                     is_number: (mode_in == uwnt_pkg::MODE_NUM), token_last: 1'b0};
                  res_cnt = res_cnt + uwnt_pkg::bcnt_type'(1);
               end
               for (int i = 0; i < 3; i++) begin
                  if (i < int'(pend_cnt_in)) begin
                     res_list[res_cnt[uwnt_pkg::BSEL_W-1:0]] = '{
                        token_byte: uwnt_pkg::lower_byte(pend_in[i]),
                        is_number: 1'b0, token_last: 1'b0};
                     res_cnt = res_cnt + uwnt_pkg::bcnt_type'(1);
                  end
               end
               held_byte_in  = uwnt_pkg::lower_byte(feed_byte);
               held_valid_in = 1'b1;
               mode_in       = uwnt_pkg::MODE_WORD;
               pend_cnt_in   = 2'd0;
               owed_in       = 2'd0;
            end else begin
               if (pend_cnt_in != 2'd3) begin
                  pend_in[pend_cnt_in] = feed_byte;
                  pend_cnt_in          = pend_cnt_in + 2'd1;
               end
               owed_in = owed_in - 2'd1;
            end
         end else if (pend_cnt_in != 2'd0) begin
            // joiner waiting for a letter
            if (feed_cls.alpha) begin
               if (held_valid_in) begin
                  res_list[res_cnt[uwnt_pkg::BSEL_W-1:0]] = '{token_byte: held_byte_in,
                     is_number: (mode_in == uwnt_pkg::MODE_NUM), token_last: 1'b0};
                  res_cnt = res_cnt + uwnt_pkg::bcnt_type'(1);
               end
               res_list[res_cnt[uwnt_pkg::BSEL_W-1:0]] = '{token_byte: pend_in[0],
                  is_number: 1'b0, token_last: 1'b0};
               res_cnt       = res_cnt + uwnt_pkg::bcnt_type'(1);
               held_byte_in  = uwnt_pkg::lower_byte(feed_byte);
               held_valid_in = 1'b1;
               pend_cnt_in   = 2'd0;
            end else if ((feed_cls.lead2 || feed_cls.lead3) && (pend_cnt_in != 2'd3)) begin
               pend_in[pend_cnt_in] = feed_byte;
               pend_cnt_in          = pend_cnt_in + 2'd1;
               owed_in              = feed_cls.lead2 ? 2'd1 : 2'd2;
            end else begin
               end_tok     = 1'b1;
               pend_cnt_in = 2'd0;
               owed_in     = 2'd0;
               top         = 1'b1;
            end
         end else if (mode_in == uwnt_pkg::MODE_WORD) begin
            // inside a word
            if (feed_cls.alpha) begin
               if (held_valid_in) begin
                  res_list[res_cnt[uwnt_pkg::BSEL_W-1:0]] = '{token_byte: held_byte_in,
                     is_number: 1'b0, token_last: 1'b0};
                  res_cnt = res_cnt + uwnt_pkg::bcnt_type'(1);
               end
               held_byte_in  = uwnt_pkg::lower_byte(feed_byte);
               held_valid_in = 1'b1;
            end else if (feed_cls.lead2 || feed_cls.lead3) begin
               pend_in[0]  = feed_byte;
               pend_cnt_in = 2'd1;
               owed_in     = feed_cls.lead2 ? 2'd1 : 2'd2;
            end else if (feed_cls.joiner) begin
               pend_in[0]  = feed_byte;
               pend_cnt_in = 2'd1;
               owed_in     = 2'd0;
            end else begin
               end_tok = 1'b1;
               top     = 1'b1;
            end
         end else if (mode_in == uwnt_pkg::MODE_NUM) begin
            // inside a number
            if (feed_cls.digit || feed_cls.dot) begin
               if (held_valid_in) begin
                  res_list[res_cnt[uwnt_pkg::BSEL_W-1:0]] = '{token_byte: held_byte_in,
                     is_number: 1'b1, token_last: 1'b0};
                  res_cnt = res_cnt + uwnt_pkg::bcnt_type'(1);
               end
               held_byte_in  = feed_byte;
               held_valid_in = 1'b1;
            end else begin
               end_tok = 1'b1;
               top     = 1'b1;
            end
         end else begin
            top = 1'b1;
         end
      end

      // token end: last beat from the held byte
      if (end_tok || do_flush) begin
         if (held_valid_in) begin
            res_list[res_cnt[uwnt_pkg::BSEL_W-1:0]] = '{token_byte: held_byte_in,
               is_number: (mode_in == uwnt_pkg::MODE_NUM), token_last: 1'b1};
            res_cnt = res_cnt + uwnt_pkg::bcnt_type'(1);
         end
         held_valid_in = 1'b0;
         mode_in       = uwnt_pkg::MODE_IDLE;
      end

      // byte seen between tokens
      if (top) begin
         mode_in = uwnt_pkg::MODE_IDLE;
         if (feed_cls.alpha) begin
            held_byte_in  = uwnt_pkg::lower_byte(feed_byte);
            held_valid_in = 1'b1;
            mode_in       = uwnt_pkg::MODE_WORD;
         end else if (feed_cls.lead2 || feed_cls.lead3) begin
            pend_in[0]  = feed_byte;
            pend_cnt_in = 2'd1;
            owed_in     = feed_cls.lead2 ? 2'd1 : 2'd2;
         end else if (feed_cls.digit) begin
            held_byte_in  = feed_byte;
            held_valid_in = 1'b1;
            mode_in       = uwnt_pkg::MODE_NUM;
         end
      end

      // line end: drop the first held byte, rescan the rest
      if (do_flush) begin
         if (pend_cnt_in != 2'd0) begin
            rep_in[0]   = pend_in[1];
            rep_in[1]   = pend_in[2];
            rep_cnt_in  = pend_cnt_in - 2'd1;
            pend_cnt_in = 2'd0;
            owed_in     = 2'd0;
         end else begin
            pop_step = 1'b1;
         end
      end
   end

   // a step runs only when its beats fit in the burst buffer
   assign go         = (do_feed || do_flush) && (res_cnt <= space);
   assign pop        = go && pop_step;
   assign push.cnt   = go ? res_cnt : '0;
   assign push.items = res_list;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= uwnt_pkg::MODE_IDLE;
         held_valid_ff <= 1'b0;
         pend_cnt_ff   <= 2'd0;
         owed_ff       <= 2'd0;
         rep_cnt_ff    <= 2'd0;
      end else if (go) begin
         mode_ff       <= mode_in;
         held_valid_ff <= held_valid_in;
         pend_cnt_ff   <= pend_cnt_in;
         owed_ff       <= owed_in;
         rep_cnt_ff    <= rep_cnt_in;
      end
   end

   // held and pending bytes
   always_ff @(posedge clock) begin
      if (go) begin
         held_byte_ff <= held_byte_in;
         pend_ff      <= pend_in;
         rep_ff       <= rep_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_owed_has_lead: assert property (@(posedge clock) disable iff (reset)
      (owed_ff != 2'd0) |-> (pend_cnt_ff != 2'd0))
      else $error("continuation bytes owed with nothing pending");
   a_full_pending_owes_one: assert property (@(posedge clock) disable iff (reset)
      (pend_cnt_ff == 2'd3) |-> (owed_ff == 2'd1))
      else $error("three pending bytes but not one byte owed");
   a_held_in_token: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (mode_ff != uwnt_pkg::MODE_IDLE))
      else $error("held token byte outside a token");
`endif

endmodule

@@ src/uwnt_burst.sv @@
// ----------------------------------------------------------------------------
// uwnt_burst
// Output buffer: takes up to four result beats from one scanner step and
// sends them one per cycle on the response channel while rsp_stall is low.
// ----------------------------------------------------------------------------
module uwnt_burst (
   input  logic                     clock,
   input  logic                     reset,
   input  uwnt_pkg::burst_push_type push,
   output uwnt_pkg::bcnt_type       space,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_token_byte,
   output logic                     rsp_is_number,
   output logic                     rsp_token_last
);

   uwnt_pkg::result_type [uwnt_pkg::BURST_DEPTH-1:0] buf_ff;
   uwnt_pkg::result_type [uwnt_pkg::BURST_DEPTH-1:0] buf_in;
   uwnt_pkg::bcnt_type cnt_ff;
   uwnt_pkg::bcnt_type cnt_in;
   uwnt_pkg::bcnt_type cnt_after;
   logic               drain;

   assign drain     = (cnt_ff != '0) && !rsp_stall;
   assign cnt_after = cnt_ff - uwnt_pkg::bcnt_type'(drain);
   assign space     = uwnt_pkg::BURST_DEPTH_CNT - cnt_after;

   // shift out the sent beat, append the new ones behind the rest
   always_comb begin : append
      uwnt_pkg::bcnt_type slot;
      uwnt_pkg::bcnt_type rel;
      buf_in = buf_ff;
      slot   = '0;
      rel    = '0;
      if (drain) begin
         for (int i = 0; i < uwnt_pkg::BURST_DEPTH - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
      end
      for (int i = 0; i < uwnt_pkg::BURST_DEPTH; i++) begin
         slot = uwnt_pkg::bcnt_type'(i);
         rel  = slot - cnt_after;
         if ((slot >= cnt_after) && (rel < push.cnt)) begin
            buf_in[i] = push.items[rel[uwnt_pkg::BSEL_W-1:0]];
         end
      end
      cnt_in = cnt_after + push.cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign rsp_valid      = (cnt_ff != '0);
   assign rsp_token_byte = buf_ff[0].token_byte;
   assign rsp_is_number  = buf_ff[0].is_number;
   assign rsp_token_last = buf_ff[0].token_last;

`ifndef NO_ASSERTIONS
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (push.cnt != '0) |-> (push.cnt <= space))
      else $error("burst buffer overrun");
`endif

endmodule

@@ src/utf8_word_number_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_word_number_tokenizer_unit
// Splits a stream of text bytes into word and number tokens and sends the
// token bytes with a last mark and a word/number kind.
// ----------------------------------------------------------------------------
//
//   channel  dir  beat fields                        handshake
//   req_     in   data_byte, end_of_line             req_valid / req_stall
//   rsp_     out  token_byte, is_number, token_last  rsp_valid / rsp_stall
//
// One text byte per cycle while the byte queue has room; the scanner runs one
// byte a cycle, bounded by the four-entry output buffer when a byte gives
// several beats (up to four when it completes a multibyte letter). Beats leave
// one per cycle while rsp_stall is low. An end-of-line beat closes the token
// and rescans the bytes of an unfinished letter before it leaves the queue.
// Reset is synchronous and clears queue, scanner state and output buffer.
// req_stall rises only when the four-entry byte queue is full.
module utf8_word_number_tokenizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_is_number,
   output logic       rsp_token_last
);

   logic                      queue_full;
   logic                      q_push;
   logic                      q_pop;
   uwnt_pkg::queue_entry_type q_entry;
   uwnt_pkg::queue_out_type   q_out;
   uwnt_pkg::bcnt_type        burst_space;
   uwnt_pkg::burst_push_type  burst_push;

   // accept and classify
   uwnt_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_line (req_end_of_line),
      .queue_full      (queue_full),
      .push            (q_push),
      .entry           (q_entry)
   );

   // byte queue
   uwnt_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .entry (q_entry),
      .pop   (q_pop),
      .full  (queue_full),
      .q_out (q_out)
   );

   // token scanner
   uwnt_scan u_scan (
      .clock (clock),
      .reset (reset),
      .q_out (q_out),
      .pop   (q_pop),
      .space (burst_space),
      .push  (burst_push)
   );

   // output buffer
   uwnt_burst u_burst (
      .clock          (clock),
      .reset          (reset),
      .push           (burst_push),
      .space          (burst_space),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_byte (rsp_token_byte),
      .rsp_is_number  (rsp_is_number),
      .rsp_token_last (rsp_token_last)
   );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the word and number tokenizer against a cycle-free predictor of its
// token beats. Text bytes and line ends go in as directed and random beats
// with sender gaps. The receiver stalls at random and once holds off long
// enough to back up the input. Every result beat is compared in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_BEATS  = 140;
   localparam int HOLD_OFF_LEN  = 80;
   localparam int PRESSURE_SPAN = 30;
   localparam int DRAIN_CYCLES  = 24;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [7:0] data;
      logic       eol;
   } text_beat_type;

   // predictor and in-order store of the token beats still owed
   class token_scoreboard;
      uwnt_pkg::result_type token_beats_due[$];
      uwnt_pkg::mode_type   scan_mode = uwnt_pkg::MODE_IDLE;
      logic [7:0] held_byte = 8'h00;
      bit         held_ok = 1'b0;
      logic [7:0] pend[3];
      int         pend_cnt = 0;
      int         owed = 0;
      int         step_beats = 0;
      int         mismatches = 0;
      int         beats_in = 0;
      int         line_ends = 0;
      int         beats_checked = 0;
      int         words = 0;
      int         numbers = 0;

      function bit is_letter(logic [7:0] b);
         return (b >= uwnt_pkg::CH_LOWER_A && b <= uwnt_pkg::CH_LOWER_Z) ||
                (b >= uwnt_pkg::CH_UPPER_A && b <= uwnt_pkg::CH_UPPER_Z);
      endfunction

      function bit is_digit_char(logic [7:0] b);
         return b >= uwnt_pkg::CH_DIGIT_0 && b <= uwnt_pkg::CH_DIGIT_9;
      endfunction

      function bit opens_pair(logic [7:0] b);
         return b >= 8'hC0 && b < 8'hE0;
      endfunction

      function bit opens_triple(logic [7:0] b);
         return b >= 8'hE0 && b < 8'hF0;
      endfunction

      function logic [7:0] fold_case(logic [7:0] b);
         if (b >= uwnt_pkg::CH_UPPER_A && b <= uwnt_pkg::CH_UPPER_Z) begin
            return b + 8'd32;
         end
         return b;
      endfunction

      // at most five beats come out of one text beat
      function void push_beat(logic [7:0] b, logic num, logic last);
         uwnt_pkg::result_type r;
         if (step_beats < 5) begin
            r.token_byte = b;
            r.is_number  = num;
            r.token_last = last;
            token_beats_due = {token_beats_due, r};
            step_beats++;
         end
      endfunction

      function void emit_held(logic last);
         if (held_ok) begin
            push_beat(held_byte, scan_mode == uwnt_pkg::MODE_NUM, last);
         end
         if (last) begin
            held_ok = 1'b0;
         end
      endfunction

      function void end_token();
         emit_held(1'b1);
         scan_mode = uwnt_pkg::MODE_IDLE;
      endfunction

      function void hold(logic [7:0] b);
         held_byte = b;
         held_ok   = 1'b1;
      endfunction

      function void start_lead(logic [7:0] b);
         pend[0]  = b;
         pend_cnt = 1;
         owed     = opens_pair(b) ? 1 : 2;
      endfunction

      // byte between tokens with nothing pending
      function void top_level(logic [7:0] b);
         scan_mode = uwnt_pkg::MODE_IDLE;
         if (is_letter(b)) begin
            hold(fold_case(b));
            scan_mode = uwnt_pkg::MODE_WORD;
         end else if (opens_pair(b) || opens_triple(b)) begin
            start_lead(b);
         end else if (is_digit_char(b)) begin
            hold(b);
            scan_mode = uwnt_pkg::MODE_NUM;
         end
      endfunction

      function void scan_byte(logic [7:0] b);
         int n;
         if (pend_cnt > 0 && owed > 0) begin
            // multibyte letter in progress
            if (owed == 1) begin
               n = pend_cnt;
               emit_held(1'b0);
               for (int i = 0; i < n && i < 3; i++) begin
                  push_beat(fold_case(pend[i]), 1'b0, 1'b0);
               end
               hold(fold_case(b));
               scan_mode = uwnt_pkg::MODE_WORD;
               pend_cnt  = 0;
               owed      = 0;
            end else begin
               if (pend_cnt < 3) begin
                  pend[pend_cnt] = b;
                  pend_cnt++;
               end
               owed--;
            end
         end else if (pend_cnt > 0) begin
            // joiner waiting for a letter
            if (is_letter(b)) begin
               emit_held(1'b0);
               push_beat(pend[0], 1'b0, 1'b0);
               hold(fold_case(b));
               pend_cnt = 0;
            end else if ((opens_pair(b) || opens_triple(b)) && pend_cnt < 3) begin
               pend[pend_cnt] = b;
               pend_cnt++;
               owed = opens_pair(b) ? 1 : 2;
            end else begin
               end_token();
               pend_cnt = 0;
               owed     = 0;
               top_level(b);
            end
         end else if (scan_mode == uwnt_pkg::MODE_WORD) begin
            if (is_letter(b)) begin
               emit_held(1'b0);
               hold(fold_case(b));
            end else if (opens_pair(b) || opens_triple(b)) begin
               start_lead(b);
            end else if (b == uwnt_pkg::CH_APOS || b == uwnt_pkg::CH_HYPHEN) begin
               pend[0]  = b;
               pend_cnt = 1;
               owed     = 0;
            end else begin
               end_token();
               top_level(b);
            end
         end else if (scan_mode == uwnt_pkg::MODE_NUM) begin
            if (is_digit_char(b) || b == uwnt_pkg::CH_DOT) begin
               emit_held(1'b0);
               hold(b);
            end else begin
               end_token();
               top_level(b);
            end
         end else begin
            top_level(b);
         end
      endfunction

      // line end: close the token, drop the first held-back byte, rescan the rest
      function void close_line();
         logic [7:0] tmp[3];
         int         n;
         end_token();
         while (pend_cnt > 0) begin
            tmp      = pend;
            n        = pend_cnt;
            pend_cnt = 0;
            owed     = 0;
            for (int i = 1; i < n && i < 3; i++) begin
               scan_byte(tmp[i]);
            end
            end_token();
         end
      endfunction

      function void take_text_beat(logic [7:0] b, logic eol);
         step_beats = 0;
         beats_in++;
         if (eol) begin
            line_ends++;
            close_line();
         end else begin
            scan_byte(b);
         end
      endfunction

      function void check_token_beat(uwnt_pkg::result_type got);
         uwnt_pkg::result_type want;
         if (token_beats_due.size() == 0) begin
            $display("%0t: token beat with nothing expected: expected none, got %02h/%0b/%0b",
                     $time, got.token_byte, got.is_number, got.token_last);
            mismatches++;
            return;
         end
         want = token_beats_due.pop_front();
         beats_checked++;
         if (got.token_byte !== want.token_byte) begin
            $display("%0t: token_byte mismatch: expected %02h, got %02h",
                     $time, want.token_byte, got.token_byte);
            mismatches++;
         end
         if (got.is_number !== want.is_number) begin
            $display("%0t: is_number mismatch: expected %0b, got %0b",
                     $time, want.is_number, got.is_number);
            mismatches++;
         end
         if (got.token_last !== want.token_last) begin
            $display("%0t: token_last mismatch: expected %0b, got %0b",
                     $time, want.token_last, got.token_last);
            mismatches++;
         end
         if (got.token_last === 1'b1) begin
            if (got.is_number) begin
               numbers++;
            end else begin
               words++;
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_line = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_token_byte;
   logic       rsp_is_number;
   logic       rsp_token_last;

   token_scoreboard sb;
   text_beat_type   text[$];
   int              burst_left = 0;
   int              cycle_count = 0;
   bit              hold_off_req = 1'b0;
   bit              drain = 1'b0;
   int              hold_off_left = 0;
   int              stall_style = 0;
   int              stall_phase_left = 0;

   utf8_word_number_tokenizer_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_line (req_end_of_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_byte  (rsp_token_byte),
      .rsp_is_number   (rsp_is_number),
      .rsp_token_last  (rsp_token_last)
   );

   always #5 clock = ~clock;

   task automatic add_byte(input logic [7:0] b);
      text_beat_type t;
      t.data = b;
      t.eol  = 1'b0;
      text = {text, t};
   endtask

   // line end beats carry a random, ignored data byte
   task automatic add_eol();
      text_beat_type t;
      t.data = 8'($urandom);
      t.eol  = 1'b1;
      text = {text, t};
   endtask

   // continuation byte, sometimes a random byte or cut off by a line end
   task automatic add_follow_byte();
      if ($urandom_range(0, 9) == 0) begin
         add_eol();
      end else if ($urandom_range(0, 3) == 0) begin
         add_byte(8'($urandom));
      end else begin
         add_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
   endtask

   // mostly text-like content with some noise and broken sequences
   task automatic add_random_text(input int count);
      int target;
      int pick;
      target = text.size() + count;
      while (text.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            if ($urandom_range(0, 1) != 0) begin
               add_byte(8'($urandom_range(uwnt_pkg::CH_UPPER_A, uwnt_pkg::CH_UPPER_Z)));
            end else begin
               add_byte(8'($urandom_range(uwnt_pkg::CH_LOWER_A, uwnt_pkg::CH_LOWER_Z)));
            end
         end else if (pick < 38) begin
            add_byte(8'($urandom_range(8'hC0, 8'hDF)));
            add_follow_byte();
         end else if (pick < 43) begin
            add_byte(8'($urandom_range(8'hE0, 8'hEF)));
            add_follow_byte();
            add_follow_byte();
         end else if (pick < 50) begin
            add_byte($urandom_range(0, 1) != 0 ? uwnt_pkg::CH_APOS : uwnt_pkg::CH_HYPHEN);
         end else if (pick < 62) begin
            add_byte(8'($urandom_range(uwnt_pkg::CH_DIGIT_0, uwnt_pkg::CH_DIGIT_9)));
         end else if (pick < 67) begin
            add_byte(uwnt_pkg::CH_DOT);
         end else if (pick < 77) begin
            add_byte(8'($urandom_range(8'h00, 8'h40)));
         end else if (pick < 85) begin
            add_eol();
         end else if (pick < 92) begin
            add_byte(8'($urandom));
         end else begin
            add_byte(8'($urandom_range(8'hF0, 8'hFF)));
         end
      end
   endtask

   // offer one beat and hold it until accepted
   task automatic send_beat(input text_beat_type t);
      req_valid       <= 1'b1;
      req_data_byte   <= t.data;
      req_end_of_line <= t.eol;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic send_span(input int lo, input int hi, input bit gaps);
      for (int i = lo; i < hi; i++) begin
         if (gaps && burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         if (burst_left > 0) begin
            burst_left--;
         end
         send_beat(text[i]);
      end
   endtask

   task automatic wait_all_tokens();
      @(posedge clock);
      while (sb.token_beats_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // monitors on both channels, then the receiver stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.take_text_beat(req_data_byte, req_end_of_line);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_token_beat('{token_byte: rsp_token_byte, is_number: rsp_is_number,
                                  token_last: rsp_token_last});
         end
      end
      if (hold_off_req) begin
         hold_off_req  = 1'b0;
         hold_off_left = HOLD_OFF_LEN;
      end
      if (stall_phase_left == 0) begin
         stall_style      = $urandom_range(0, 2);
         stall_phase_left = $urandom_range(10, 60);
      end else begin
         stall_phase_left--;
      end
      if (drain) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d token beats outstanding",
                  cycle_count, sb.token_beats_due.size());
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      int first;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed line: case folding, joiners, multibyte letters, number after word
      add_byte("A");
      add_byte("b");
      add_byte(uwnt_pkg::CH_HYPHEN);
      add_byte("Z");
      add_byte(uwnt_pkg::CH_APOS);
      add_byte(8'hC3);
      add_byte(8'h89);
      add_byte("9");
      add_byte(uwnt_pkg::CH_DOT);
      add_byte("0");
      // lead above EF skipped, then a three-byte letter cut by the line end
      add_byte(8'hF5);
      add_byte(8'hE2);
      add_byte("A");
      add_eol();
      // joiner with no letter after it
      add_byte("x");
      add_byte(uwnt_pkg::CH_HYPHEN);
      add_byte("7");
      add_eol();
      // empty line
      add_eol();
      // byte extremes, upper case continuation byte, joiner plus a cut letter
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(8'hDF);
      add_byte("Z");
      add_byte(uwnt_pkg::CH_APOS);
      add_byte(8'hEF);
      add_byte(8'hBF);
      add_eol();
      send_span(0, text.size(), 1'b1);

      // sender pause until everything is out
      req_valid <= 1'b0;
      wait_all_tokens();

      // random text, opening with a gapless stretch against a long receiver hold-off
      first = text.size();
      add_random_text(RANDOM_BEATS);
      hold_off_req = 1'b1;
      send_span(first, first + PRESSURE_SPAN, 1'b0);
      send_span(first + PRESSURE_SPAN, text.size(), 1'b1);

      req_valid <= 1'b0;
      drain = 1'b1;
      wait_all_tokens();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d text beats in (%0d line ends), %0d token beats checked",
               sb.beats_in, sb.line_ends, sb.beats_checked);
      $display("tb: %0d word and %0d number tokens seen, %0d mismatches",
               sb.words, sb.numbers, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
